>>> rtl/f64fma_pkg.sv
package f64fma_pkg;

    localparam int NumStages = 11;

    localparam logic [63:0] DefaultNan = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] QuietBit   = 64'h0008_0000_0000_0000;
    localparam logic [10:0] ExpAll     = 11'h7FF;

    typedef logic [NumStages-1:0] stage_en_t;

    // product and aligned-ready addend leaving the multiplier
    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               sp;
        logic               sc;
        logic               cz;
        logic [105:0]       prod;
        logic [127:0]       cw;
        logic signed [13:0] ecx;
        logic [11:0]        xsum;
    } mul_t;

    // signed-magnitude sum leaving the adder
    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               s;
        logic [127:0]       m;
        logic signed [13:0] e;
    } sum_t;

    // index of the highest set bit, zero for an empty word
    function automatic logic [6:0] top_bit(input logic [127:0] v);
        logic [6:0] r;
        r = '0;
        for (int i = 0; i < 128; i++)
        begin
            if (v[i])
            begin
                r = 7'(i);
            end
        end
        return r;
    endfunction

    // right shift, any bit shifted out is ORed into bit 0
    function automatic logic [127:0] jam_shr(input logic [127:0] v, input logic [13:0] n);
        logic [127:0] r;
        logic         lost;
        if (|n[13:7])
        begin
            r    = '0;
            lost = |v;
        end
        else
        begin
            r    = v >> n[6:0];
            lost = |(v & ~({128{1'b1}} << n[6:0]));
        end
        r[0] = r[0] | lost;
        return r;
    endfunction

endpackage

>>> rtl/f64fma_pipe_ctrl.sv
module f64fma_pipe_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output f64fma_pkg::stage_en_t       en
);

    localparam int N = f64fma_pkg::NumStages;

    logic [N-1:0] v_reg;
    logic [N-1:0] v_next;
    logic [N-1:0] ready;

    // a stage may load when it is empty or its item moves on
    always_comb
    begin
        ready[N-1] = !v_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            ready[i] = !v_reg[i] || ready[i+1];
        end
        v_next[0] = ready[0] ? in_valid : v_reg[0];
        for (int i = 1; i < N; i++)
        begin
            v_next[i] = ready[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign en        = ready;
    assign in_ready  = ready[0];
    assign out_valid = v_reg[N-1];

`ifndef SYNTHESIS
    a_fill_rate: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(v_reg) <= $past($countones(v_reg)) + 1)
        else $error("pipeline occupancy grew by more than one");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg && !out_ready) |-> !in_ready)
        else $error("input taken while pipeline full and stalled");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("transfer did not enter first stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !v_reg[N-2]) |=> !out_valid)
        else $error("last stage kept an item that was delivered");
`endif

endmodule

>>> rtl/f64fma_mul.sv
module f64fma_mul (
    input  logic               clk,
    input  logic [1:0]         en,
    input  logic [63:0]        operand_a,
    input  logic [63:0]        operand_b,
    input  logic [63:0]        addend_c,
    output f64fma_pkg::mul_t   mul_out
);

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               sp;
        logic               sc;
        logic               cz;
        logic [53:0]        pp_ll;
        logic [52:0]        pp_lh;
        logic [52:0]        pp_hl;
        logic [51:0]        pp_hh;
        logic [127:0]       cw;
        logic signed [13:0] ecx;
        logic [11:0]        xsum;
    } dec_t;

    dec_t             s0_reg;
    dec_t             s0_next;
    f64fma_pkg::mul_t s1_reg;
    f64fma_pkg::mul_t s1_next;

    logic [10:0] ea, eb, ec;
    logic        ainf, binf, cinf, nan_a, nan_b, nan_c, az, bz, cz;
    logic [52:0] ma, mb, mc;
    logic [10:0] xa, xb, xc;
    logic [6:0]  pc, lshc;
    logic        sa, sb, sc, sp;

    always_comb
    begin
        sa    = operand_a[63];
        sb    = operand_b[63];
        sc    = addend_c[63];
        sp    = sa ^ sb;
        ea    = operand_a[62:52];
        eb    = operand_b[62:52];
        ec    = addend_c[62:52];
        ainf  = ea == f64fma_pkg::ExpAll;
        binf  = eb == f64fma_pkg::ExpAll;
        cinf  = ec == f64fma_pkg::ExpAll;
        nan_a = ainf && (operand_a[51:0] != '0);
        nan_b = binf && (operand_b[51:0] != '0);
        nan_c = cinf && (addend_c[51:0] != '0);
        az    = operand_a[62:0] == '0;
        bz    = operand_b[62:0] == '0;
        cz    = addend_c[62:0] == '0;
        ma    = {ea != '0, operand_a[51:0]};
        mb    = {eb != '0, operand_b[51:0]};
        mc    = {ec != '0, addend_c[51:0]};
        xa    = (ea == '0) ? 11'd1 : ea;
        xb    = (eb == '0) ? 11'd1 : eb;
        xc    = (ec == '0) ? 11'd1 : ec;

        s0_next.spec     = 1'b1;
        s0_next.spec_val = '0;
        if (nan_a)
        begin
            s0_next.spec_val = operand_a | f64fma_pkg::QuietBit;
        end
        else if (nan_b)
        begin
            s0_next.spec_val = operand_b | f64fma_pkg::QuietBit;
        end
        else if (nan_c)
        begin
            s0_next.spec_val = addend_c | f64fma_pkg::QuietBit;
        end
        else if (ainf || binf)
        begin
            if (az || bz || (cinf && (sc != sp)))
            begin
                s0_next.spec_val = f64fma_pkg::DefaultNan;
            end
            else
            begin
                s0_next.spec_val = {sp, f64fma_pkg::ExpAll, 52'd0};
            end
        end
        else if (cinf)
        begin
            s0_next.spec_val = addend_c;
        end
        else if (az || bz)
        begin
            s0_next.spec_val = cz ? {sp & sc, 63'd0} : addend_c;
        end
        else
        begin
            s0_next.spec = 1'b0;
        end

        s0_next.sp = sp;
        s0_next.sc = sc;
        s0_next.cz = cz;

        // 53x53 split into four partial products of at most 27 bits a side
        s0_next.pp_ll = ma[26:0] * mb[26:0];
        s0_next.pp_lh = ma[26:0] * mb[52:27];
        s0_next.pp_hl = ma[52:27] * mb[26:0];
        s0_next.pp_hh = ma[52:27] * mb[52:27];

        // addend with its leading one at bit 125
        pc           = f64fma_pkg::top_bit({75'd0, mc});
        lshc         = 7'd125 - pc;
        s0_next.cw   = {75'd0, mc} << lshc;
        s0_next.ecx  = 14'(xc) - 14'd1075 - 14'(lshc);
        s0_next.xsum = 12'(xa) + 12'(xb);
    end

    always_comb
    begin
        s1_next.spec     = s0_reg.spec;
        s1_next.spec_val = s0_reg.spec_val;
        s1_next.sp       = s0_reg.sp;
        s1_next.sc       = s0_reg.sc;
        s1_next.cz       = s0_reg.cz;
        s1_next.prod     = 106'(s0_reg.pp_ll)
                         + ((106'(s0_reg.pp_lh) + 106'(s0_reg.pp_hl)) << 27)
                         + (106'(s0_reg.pp_hh) << 54);
        s1_next.cw       = s0_reg.cw;
        s1_next.ecx      = s0_reg.ecx;
        s1_next.xsum     = s0_reg.xsum;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_reg <= s0_next;
        end
        if (en[1])
        begin
            s1_reg <= s1_next;
        end
    end

    assign mul_out = s1_reg;

endmodule

>>> rtl/f64fma_add.sv
module f64fma_add (
    input  logic               clk,
    input  logic [4:0]         en,
    input  f64fma_pkg::mul_t   mul_in,
    output f64fma_pkg::sum_t   sum_out
);

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               sp;
        logic               sc;
        logic               cz;
        logic [105:0]       prod;
        logic [6:0]         lsh;
        logic signed [13:0] ep;
        logic [127:0]       cw;
        logic signed [13:0] ecx;
    } nrm_t;

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               sp;
        logic               sc;
        logic [127:0]       pn;
        logic [127:0]       cw;
        logic               sel;
        logic [13:0]        shamt;
        logic signed [13:0] e;
    } alg_t;

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               sp;
        logic               sc;
        logic [127:0]       x;
        logic [127:0]       y;
        logic signed [13:0] e;
    } opd_t;

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               sp;
        logic               sc;
        logic               sub;
        logic [128:0]       d;
        logic signed [13:0] e;
    } raw_t;

    nrm_t             s2_reg, s2_next;
    alg_t             s3_reg, s3_next;
    opd_t             s4_reg, s4_next;
    raw_t             s5_reg, s5_next;
    f64fma_pkg::sum_t s6_reg, s6_next;

    logic [6:0]   pp;
    logic [127:0] jsrc, jres;
    logic         neg;

    // product leading one position
    always_comb
    begin
        pp               = f64fma_pkg::top_bit({22'd0, mul_in.prod});
        s2_next.spec     = mul_in.spec;
        s2_next.spec_val = mul_in.spec_val;
        s2_next.sp       = mul_in.sp;
        s2_next.sc       = mul_in.sc;
        s2_next.cz       = mul_in.cz;
        s2_next.prod     = mul_in.prod;
        s2_next.lsh      = 7'd125 - pp;
        s2_next.ep       = 14'(mul_in.xsum) - 14'd2150 - 14'(7'd125 - pp);
        s2_next.cw       = mul_in.cw;
        s2_next.ecx      = mul_in.ecx;
    end

    // normalize product, pick the operand to align
    always_comb
    begin
        s3_next.spec     = s2_reg.spec;
        s3_next.spec_val = s2_reg.spec_val;
        s3_next.sp       = s2_reg.sp;
        s3_next.sc       = s2_reg.sc;
        s3_next.pn       = {22'd0, s2_reg.prod} << s2_reg.lsh;
        if (s2_reg.cz)
        begin
            s3_next.cw    = '0;
            s3_next.sel   = 1'b1;
            s3_next.shamt = '0;
            s3_next.e     = s2_reg.ep;
        end
        else if (s2_reg.ep >= s2_reg.ecx)
        begin
            s3_next.cw    = s2_reg.cw;
            s3_next.sel   = 1'b1;
            s3_next.shamt = 14'(s2_reg.ep - s2_reg.ecx);
            s3_next.e     = s2_reg.ep;
        end
        else
        begin
            s3_next.cw    = s2_reg.cw;
            s3_next.sel   = 1'b0;
            s3_next.shamt = 14'(s2_reg.ecx - s2_reg.ep);
            s3_next.e     = s2_reg.ecx;
        end
    end

    // align the smaller operand with sticky jam
    always_comb
    begin
        jsrc             = s3_reg.sel ? s3_reg.cw : s3_reg.pn;
        jres             = f64fma_pkg::jam_shr(jsrc, s3_reg.shamt);
        s4_next.spec     = s3_reg.spec;
        s4_next.spec_val = s3_reg.spec_val;
        s4_next.sp       = s3_reg.sp;
        s4_next.sc       = s3_reg.sc;
        s4_next.x        = s3_reg.sel ? s3_reg.pn : jres;
        s4_next.y        = s3_reg.sel ? jres : s3_reg.cw;
        s4_next.e        = s3_reg.e;
    end

    always_comb
    begin
        s5_next.spec     = s4_reg.spec;
        s5_next.spec_val = s4_reg.spec_val;
        s5_next.sp       = s4_reg.sp;
        s5_next.sc       = s4_reg.sc;
        s5_next.sub      = s4_reg.sp != s4_reg.sc;
        s5_next.e        = s4_reg.e;
        if (s4_reg.sp != s4_reg.sc)
        begin
            s5_next.d = {1'b0, s4_reg.x} - {1'b0, s4_reg.y};
        end
        else
        begin
            s5_next.d = {1'b0, s4_reg.x} + {1'b0, s4_reg.y};
        end
    end

    // magnitude and sign; exact cancellation gives +0
    always_comb
    begin
        neg              = s5_reg.sub && s5_reg.d[128];
        s6_next.m        = neg ? (~s5_reg.d[127:0] + 128'd1) : s5_reg.d[127:0];
        s6_next.s        = neg ? s5_reg.sc : s5_reg.sp;
        s6_next.e        = s5_reg.e;
        s6_next.spec     = s5_reg.spec;
        s6_next.spec_val = s5_reg.spec_val;
        if (!s5_reg.spec && s5_reg.sub && (s5_reg.d == '0))
        begin
            s6_next.spec     = 1'b1;
            s6_next.spec_val = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s2_reg <= s2_next;
        end
        if (en[1])
        begin
            s3_reg <= s3_next;
        end
        if (en[2])
        begin
            s4_reg <= s4_next;
        end
        if (en[3])
        begin
            s5_reg <= s5_next;
        end
        if (en[4])
        begin
            s6_reg <= s6_next;
        end
    end

    assign sum_out = s6_reg;

endmodule

>>> rtl/f64fma_round.sv
module f64fma_round (
    input  logic               clk,
    input  logic [3:0]         en,
    input  f64fma_pkg::sum_t   sum_in,
    output logic [63:0]        fma_result
);

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               s;
        logic [127:0]       m;
        logic [6:0]         p;
        logic signed [13:0] e;
    } lz_t;

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               s;
        logic [127:0]       m;
        logic signed [13:0] q;
        logic signed [13:0] sh;
    } pos_t;

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               s;
        logic [53:0]        sig;
        logic               rb;
        logic               sticky;
        logic signed [13:0] q;
    } sft_t;

    lz_t         s7_reg, s7_next;
    pos_t        s8_reg, s8_next;
    sft_t        s9_reg, s9_next;
    logic [63:0] res_reg, res_next;

    logic signed [13:0] et, qb, nsh, n;
    logic [127:0]       sv;
    logic               inc;
    logic [53:0]        sr, sig2;
    logic signed [13:0] q2;
    logic [13:0]        bexp;
    logic [62:0]        body;

    always_comb
    begin
        s7_next.spec     = sum_in.spec;
        s7_next.spec_val = sum_in.spec_val;
        s7_next.s        = sum_in.s;
        s7_next.m        = sum_in.m;
        s7_next.p        = f64fma_pkg::top_bit(sum_in.m);
        s7_next.e        = sum_in.e;
    end

    // result exponent, clamped at the subnormal floor
    always_comb
    begin
        et               = 14'(s7_reg.p) + s7_reg.e;
        qb               = (et < -14'sd1022) ? -14'sd1022 : et;
        s8_next.spec     = s7_reg.spec;
        s8_next.spec_val = s7_reg.spec_val;
        s8_next.s        = s7_reg.s;
        s8_next.m        = s7_reg.m;
        s8_next.q        = qb - 14'sd52;
        s8_next.sh       = qb - 14'sd52 - s7_reg.e;
    end

    always_comb
    begin
        nsh              = -s8_reg.sh;
        n                = s8_reg.sh - 14'sd1;
        sv               = '0;
        s9_next.spec     = s8_reg.spec;
        s9_next.spec_val = s8_reg.spec_val;
        s9_next.s        = s8_reg.s;
        s9_next.q        = s8_reg.q;
        if (s8_reg.sh <= 14'sd0)
        begin
            sv             = s8_reg.m << nsh[5:0];
            s9_next.sig    = sv[53:0];
            s9_next.rb     = 1'b0;
            s9_next.sticky = 1'b0;
        end
        else if (|n[13:7])
        begin
            s9_next.sig    = '0;
            s9_next.rb     = 1'b0;
            s9_next.sticky = |s8_reg.m;
        end
        else
        begin
            sv             = s8_reg.m >> n[6:0];
            s9_next.sig    = sv[54:1];
            s9_next.rb     = sv[0];
            s9_next.sticky = |(s8_reg.m & ~({128{1'b1}} << n[6:0]));
        end
    end

    // round to nearest even and pack, carry into exponent handles subnormal to normal
    always_comb
    begin
        inc  = s9_reg.rb && (s9_reg.sticky || s9_reg.sig[0]);
        sr   = s9_reg.sig + 54'(inc);
        sig2 = sr[53] ? (sr >> 1) : sr;
        q2   = s9_reg.q + 14'(sr[53]);
        bexp = 14'(q2 + 14'sd1074);
        body = {bexp[10:0], 52'd0} + {10'd0, sig2[52:0]};
        if (s9_reg.spec)
        begin
            res_next = s9_reg.spec_val;
        end
        else if (q2 > 14'sd971)
        begin
            res_next = {s9_reg.s, f64fma_pkg::ExpAll, 52'd0};
        end
        else
        begin
            res_next = {s9_reg.s, body};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s7_reg <= s7_next;
        end
        if (en[1])
        begin
            s8_reg <= s8_next;
        end
        if (en[2])
        begin
            s9_reg <= s9_next;
        end
        if (en[3])
        begin
            res_reg <= res_next;
        end
    end

    assign fma_result = res_reg;

endmodule

>>> rtl/fp64_fused_multiply_add.sv
// channel   dir  handshake                    tdata from bit 0
// s_axis    in   s_axis_tvalid/s_axis_tready  operand_a, operand_b, addend_c (64 bits each)
// m_axis    out  m_axis_tvalid/m_axis_tready  fma_result (64 bits)
//
// eleven register stages lie between an operand transfer and the offered result
// one transfer per cycle sustained while m_axis_tready stays high; each stage holds its own valid bit
// a stalled output holds only the stages behind it that are full, bubbles still fill
// rst_n clears the valid bits only, the data path has no reset
module fp64_fused_multiply_add (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // operand_a, operand_b, addend_c
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata    // fma_result
);

    f64fma_pkg::stage_en_t en;
    f64fma_pkg::mul_t      mul_q;
    f64fma_pkg::sum_t      sum_q;

    f64fma_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .en        (en)
    );

    f64fma_mul u_mul (
        .clk       (clk),
        .en        (en[1:0]),
        .operand_a (s_axis_tdata[63:0]),
        .operand_b (s_axis_tdata[127:64]),
        .addend_c  (s_axis_tdata[191:128]),
        .mul_out   (mul_q)
    );

    f64fma_add u_add (
        .clk     (clk),
        .en      (en[6:2]),
        .mul_in  (mul_q),
        .sum_out (sum_q)
    );

    f64fma_round u_round (
        .clk        (clk),
        .en         (en[10:7]),
        .sum_in     (sum_q),
        .fma_result (m_axis_tdata)
    );

endmodule

>>> bench/fp64_fused_multiply_add_checker.sv
`timescale 1ns / 100ps

module fp64_fused_multiply_add_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,
    output int           fail_count,
    output int           pending_count
);

    localparam logic [63:0] FracMask = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] HiddenBit = 64'h0010_0000_0000_0000;
    localparam logic [63:0] PosInf = 64'h7FF0_0000_0000_0000;
    localparam int TopPos = 125;

    logic [63:0] fma_expected_q[$];

    function automatic int msb_index(input logic [127:0] v);
        int r;
        r = -1;
        for (int i = 0; i < 128; i++)
        begin
            if (v[i])
            begin
                r = i;
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] shr_sticky(input logic [127:0] v, input int n);
        logic [127:0] r;
        logic [127:0] lostmask;
        if (n <= 0)
        begin
            return v;
        end
        if (n >= 128)
        begin
            r = '0;
            r[0] = |v;
            return r;
        end
        lostmask = ~({128{1'b1}} << n);
        r = v >> n;
        r[0] = r[0] | (|(v & lostmask));
        return r;
    endfunction

    function automatic logic [63:0] round_to_f64(input logic s, input logic [127:0] m,
                                                 input int e);
        int p, et, q, sh;
        logic [127:0] t;
        logic [63:0] sig;
        logic sticky, rb;
        p = msb_index(m);
        et = p + e;
        q = ((et < -1022) ? -1022 : et) - 52;
        sh = q - e;
        if (sh <= 0)
        begin
            sig = 64'(m << (-sh));
        end
        else
        begin
            if (sh - 1 >= 128)
            begin
                t = '0;
                sticky = |m;
            end
            else
            begin
                t = m >> (sh - 1);
                sticky = (sh - 1 > 0) ? |(m & ~({128{1'b1}} << (sh - 1))) : 1'b0;
            end
            rb = t[0];
            sig = 64'(t >> 1);
            if (rb && (sticky || sig[0]))
            begin
                sig = sig + 1;
            end
            if (sig[53])
            begin
                sig = sig >> 1;
                q++;
            end
        end
        if (q > 971)
        begin
            return {s, 63'b0} | PosInf;
        end
        return {s, 63'b0} | ((64'(q + 1074) << 52) + sig);
    endfunction

    function automatic logic is_nan64(input logic [63:0] x);
        return (x[62:52] == f64fma_pkg::ExpAll) && (x[51:0] != 0);
    endfunction

    function automatic logic [63:0] fma_predict(input logic [63:0] a, input logic [63:0] b,
                                                input logic [63:0] c);
        logic sp, sc, s;
        logic ainf, binf, cinf, az, bz, cz;
        logic [127:0] prod, cw, m;
        int xa, xb, xc, pp, pc, ep, ecx, e;
        sp = a[63] ^ b[63];
        sc = c[63];
        ainf = a[62:52] == f64fma_pkg::ExpAll;
        binf = b[62:52] == f64fma_pkg::ExpAll;
        cinf = c[62:52] == f64fma_pkg::ExpAll;
        az = a[62:0] == 0;
        bz = b[62:0] == 0;
        cz = c[62:0] == 0;
        if (is_nan64(a)) return a | f64fma_pkg::QuietBit;
        if (is_nan64(b)) return b | f64fma_pkg::QuietBit;
        if (is_nan64(c)) return c | f64fma_pkg::QuietBit;
        if (ainf || binf)
        begin
            if (az || bz) return f64fma_pkg::DefaultNan;
            if (cinf && sc != sp) return f64fma_pkg::DefaultNan;
            return {sp, 63'b0} | PosInf;
        end
        if (cinf) return c;
        if (az || bz) return cz ? {sp & sc, 63'b0} : c;
        xa = (a[62:52] != 0) ? int'(a[62:52]) : 1;
        xb = (b[62:52] != 0) ? int'(b[62:52]) : 1;
        xc = (c[62:52] != 0) ? int'(c[62:52]) : 1;
        prod = 128'((a & FracMask) | ((a[62:52] != 0) ? HiddenBit : 0))
             * 128'((b & FracMask) | ((b[62:52] != 0) ? HiddenBit : 0));
        pp = msb_index(prod);
        prod = prod << (TopPos - pp);
        ep = xa + xb - 2150 - (TopPos - pp);
        if (cz)
        begin
            m = prod;
            e = ep;
            s = sp;
        end
        else
        begin
            cw = 128'((c & FracMask) | ((c[62:52] != 0) ? HiddenBit : 0));
            pc = msb_index(cw);
            cw = cw << (TopPos - pc);
            ecx = xc - 1075 - (TopPos - pc);
            if (ep >= ecx)
            begin
                cw = shr_sticky(cw, ep - ecx);
                e = ep;
            end
            else
            begin
                prod = shr_sticky(prod, ecx - ep);
                e = ecx;
            end
            if (sp == sc)
            begin
                m = prod + cw;
                s = sp;
            end
            else if (prod == cw)
            begin
                return 64'b0;
            end
            else if (prod > cw)
            begin
                m = prod - cw;
                s = sp;
            end
            else
            begin
                m = cw - prod;
                s = sc;
            end
        end
        return round_to_f64(s, m, e);
    endfunction

    assign pending_count = fma_expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                fma_expected_q.push_back(fma_predict(s_axis_tdata[63:0],
                    s_axis_tdata[127:64], s_axis_tdata[191:128]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (fma_expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected result transfer: %h", m_axis_tdata);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    logic [63:0] want;
                    want = fma_expected_q.pop_front();
                    if (want !== m_axis_tdata)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("fma_result mismatch: expected %h, got %h",
                                     want, m_axis_tdata);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> bench/fp64_fused_multiply_add_tb.sv
`timescale 1ns / 100ps

module fp64_fused_multiply_add_tb;
    localparam int StallLimit = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    int           fail_count;
    int           pending_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           quiet_cycles;

    fp64_fused_multiply_add i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fp64_fused_multiply_add_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // random binary64 pattern biased toward interesting exponents and sparse fractions
    function automatic logic [63:0] pick_f64(input int near_exp);
        logic [63:0] v;
        int kind;
        v = {$urandom, $urandom};
        kind = $urandom_range(15);
        case (kind)
            0: v[62:52] = 11'h7FF;
            1: v[62:52] = 11'h000;
            2: v[62:0] = '0;
            3: v[62:52] = 11'($urandom_range(3));
            4: v[62:52] = 11'(2044 - $urandom_range(3));
            5: v[51:0] = 52'(1) << $urandom_range(51);
            default: v[62:52] = 11'(near_exp + $urandom_range(120) - 60);
        endcase
        return v;
    endfunction

    task automatic send_op(input logic [63:0] a, input logic [63:0] b, input logic [63:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c, b, a};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        logic [63:0] a, b, c, p;
        int base;
        for (int i = 0; i < count; i++)
        begin
            base = $urandom_range(2000) + 20;
            a = pick_f64(base);
            b = pick_f64(2046 - base);
            c = pick_f64(1023 + $urandom_range(60) - 30);
            if ($urandom_range(3) == 0)
            begin
                // addend near minus the product to exercise cancellation
                p = {~(a[63] ^ b[63]), 11'(int'(a[62:52]) + int'(b[62:52]) - 1023),
                     a[51:0] ^ 52'($urandom_range(7))};
                c = p;
            end
            send_op(a, b, c);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle_pct = 16;
        recv_idle_pct = 61;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // NaN order and quieting
        send_op(64'h7FF0_0000_0000_0001, 64'hFFF8_0000_0000_0002, 64'h7FF4_0000_0000_0003);
        send_op(64'h3FF0_0000_0000_0000, 64'hFFF4_0000_0000_0002, 64'h7FF4_0000_0000_0003);
        send_op(64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000, 64'hFFF0_0000_0000_0009);
        // inf times zero, opposite and like-signed infinities, inf times finite plus finite
        send_op(64'h7FF0_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000);
        send_op(64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
        send_op(64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000);
        send_op(64'h4000_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
        // finite product, infinite addend
        send_op(64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'hFFF0_0000_0000_0000);
        // zero product cases
        send_op(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_op(64'h0000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_op(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h3FF8_0000_0000_0000);
        // exact cancellation
        send_op(64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000);
        // overflow and underflow
        send_op(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000);
        send_op(64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 64'h7CA0_0000_0000_0000);
        send_op(64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0000, 64'h0000_0000_0000_0000);
        send_op(64'h0000_0000_0000_0001, 64'h3FE8_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_op(64'h000F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001, 64'h0000_0000_0000_0001);
        send_op(64'h2000_0000_0000_0000, 64'h2000_0000_0000_0000, 64'h8010_0000_0000_0000);
        // tie to even and sticky from a tiny addend
        send_op(64'h3FF0_0000_0000_0001, 64'h3FF0_0000_0000_0001, 64'h0000_0000_0000_0001);
        send_op(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h3CA0_0000_0000_0000);
        send_op(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(64'hFFEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);

        send_random(420);
        send_idle_pct = 61;
        recv_idle_pct = 16;
        send_random(420);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(410);
        s_axis_tvalid <= 1'b0;

        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        repeat (30) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
